@@ hw/rtl/hlfe_pkg.sv @@
// Shared types, constants and helper functions of the result frame encoder.
`timescale 1ns / 1ps

package hlfe_pkg;

    // Field widths.
    localparam int CHANNELS = 10;
    localparam int CODE_W   = 4;
    localparam int CAT_W    = 3;
    localparam int UNIT_W   = 7;
    localparam int ADDR_W   = 14;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 5;
    localparam int CFG_W    = 14;
    localparam int HEX_W    = 16;

    // Frame geometry.
    localparam int FCS_SPAN = 13;

    // Configuration register indexes.
    localparam logic REG_UNIT_NUMBER = 1'b0;
    localparam logic REG_BASE_ADDR   = 1'b1;

    // Decimal ranges of the unit number and the word address.
    localparam logic [UNIT_W-1:0] UNIT_MOD = UNIT_W'(100);
    localparam logic [ADDR_W:0]   ADDR_MOD = (ADDR_W + 1)'(10000);
    localparam logic [ADDR_W-1:0] SCALE_10   = ADDR_W'(10);
    localparam logic [ADDR_W-1:0] SCALE_100  = ADDR_W'(100);
    localparam logic [ADDR_W-1:0] SCALE_1000 = ADDR_W'(1000);

    // ASCII characters of the frame.
    localparam logic [BYTE_W-1:0] CH_AT     = 8'h40;
    localparam logic [BYTE_W-1:0] CH_W      = 8'h57;
    localparam logic [BYTE_W-1:0] CH_D      = 8'h44;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] DEC_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] HEX_ALPHA = 8'h37;

    // Byte positions within one frame.
    localparam logic [IDX_W-1:0] POS_AT      = 5'd0;
    localparam logic [IDX_W-1:0] POS_UNIT_HI = 5'd1;
    localparam logic [IDX_W-1:0] POS_UNIT_LO = 5'd2;
    localparam logic [IDX_W-1:0] POS_CMD_W   = 5'd3;
    localparam logic [IDX_W-1:0] POS_CMD_D   = 5'd4;
    localparam logic [IDX_W-1:0] POS_ADDR_3  = 5'd5;
    localparam logic [IDX_W-1:0] POS_ADDR_2  = 5'd6;
    localparam logic [IDX_W-1:0] POS_ADDR_1  = 5'd7;
    localparam logic [IDX_W-1:0] POS_ADDR_0  = 5'd8;
    localparam logic [IDX_W-1:0] POS_MASK_3  = 5'd9;
    localparam logic [IDX_W-1:0] POS_MASK_2  = 5'd10;
    localparam logic [IDX_W-1:0] POS_MASK_1  = 5'd11;
    localparam logic [IDX_W-1:0] POS_MASK_0  = 5'd12;
    localparam logic [IDX_W-1:0] POS_FCS_HI  = 5'd13;
    localparam logic [IDX_W-1:0] POS_FCS_LO  = 5'd14;
    localparam logic [IDX_W-1:0] POS_STAR    = 5'd15;
    localparam logic [IDX_W-1:0] POS_CR      = 5'd16;

    typedef logic [CHANNELS-1:0] mask_t;

    typedef struct packed {
        logic [CODE_W-1:0] ch0_code;
        logic [CODE_W-1:0] ch1_code;
        logic [CODE_W-1:0] ch2_code;
        logic [CODE_W-1:0] ch3_code;
        logic [CODE_W-1:0] ch4_code;
        logic [CODE_W-1:0] ch5_code;
        logic [CODE_W-1:0] ch6_code;
        logic [CODE_W-1:0] ch7_code;
        logic [CODE_W-1:0] ch8_code;
        logic [CODE_W-1:0] ch9_code;
        logic [CAT_W-1:0]  category;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              last;
    } out_item_t;

    // One classified request as it waits between front and back.
    typedef struct packed {
        mask_t             mask;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] wide;
        wide = {4'h0, nib};
        return (nib > 4'd9) ? wide + HEX_ALPHA : wide + DEC_ZERO;
    endfunction

    function automatic logic [BYTE_W-1:0] dec_char(input logic [3:0] dig);
        return {4'h0, dig} + DEC_ZERO;
    endfunction

    // Leading decimal digit of v for a given power of ten, found by comparing
    // against its nine multiples; v must stay below ten times the scale.
    function automatic logic [3:0] dec_digit(input logic [ADDR_W-1:0] v,
                                             input logic [ADDR_W-1:0] scale);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= ADDR_W'(k * scale)) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

endpackage

@@ hw/rtl/hlfe_front.sv @@
// Front end: accepts requests, builds the match mask and the word address.
`timescale 1ns / 1ps

module hlfe_front
    import hlfe_pkg::*;
(
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    input  logic [ADDR_W-1:0] base_addr,
    input  logic              q_ready,
    output logic              q_push,
    output cmd_t              q_data
);

    logic [CODE_W-1:0] codes [CHANNELS];
    logic [ADDR_W:0]   addr_sum;
    mask_t             mask;

    always_comb begin
        codes[0] = s_data.ch0_code;
        codes[1] = s_data.ch1_code;
        codes[2] = s_data.ch2_code;
        codes[3] = s_data.ch3_code;
        codes[4] = s_data.ch4_code;
        codes[5] = s_data.ch5_code;
        codes[6] = s_data.ch6_code;
        codes[7] = s_data.ch7_code;
        codes[8] = s_data.ch8_code;
        codes[9] = s_data.ch9_code;
    end

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            mask[i] = (codes[i] == {1'b0, s_data.category});
        end
    end

    // The sum stays below twice the modulus, so one subtraction wraps it.
    assign addr_sum = {1'b0, base_addr} + (ADDR_W + 1)'({s_data.category, 1'b0});

    always_comb begin
        q_data.mask = mask;
        if (addr_sum >= ADDR_MOD) begin
            q_data.addr = ADDR_W'(addr_sum - ADDR_MOD);
        end else begin
            q_data.addr = addr_sum[ADDR_W-1:0];
        end
    end

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

endmodule

@@ hw/rtl/hlfe_queue.sv @@
// Two-entry queue of classified requests between front and back.
`timescale 1ns / 1ps

module hlfe_queue
    import hlfe_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    output logic in_ready,
    input  cmd_t wr_data,
    input  logic pop,
    output logic out_valid,
    output cmd_t rd_data
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign rd_data   = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hw/rtl/hlfe_back.sv @@
// Back end: walks one frame byte by byte into a registered output stage.
`timescale 1ns / 1ps

module hlfe_back
    import hlfe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [UNIT_W-1:0] unit_number,
    input  logic              q_valid,
    input  cmd_t              q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data
);

    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0] rem_reg, rem_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    mask_t             mask_reg, mask_next;
    logic [BYTE_W-1:0] fcs_reg, fcs_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              advance;
    logic              frame_end;
    logic [UNIT_W-1:0] unit_mod;
    logic [HEX_W-1:0]  mask_hex;
    logic [3:0]        d10, d100, d1000;
    logic [BYTE_W-1:0] cur_byte;
    logic [ADDR_W-1:0] rem_step;

    assign advance   = busy_reg && (!out_valid_reg || m_ready);
    assign frame_end = advance && (idx_reg == POS_CR);
    assign q_pop     = q_valid && (!busy_reg || frame_end);
    assign unit_mod  = (unit_number >= UNIT_MOD) ? unit_number - UNIT_MOD : unit_number;
    assign mask_hex  = HEX_W'(mask_reg);

    assign d10   = dec_digit(rem_reg, SCALE_10);
    assign d100  = dec_digit(rem_reg, SCALE_100);
    assign d1000 = dec_digit(rem_reg, SCALE_1000);

    // Byte for the current position; the decimal remainder loses its leading
    // digit each time a digit other than the last of a number is sent.
    always_comb begin
        cur_byte = CH_CR;
        rem_step = rem_reg;
        unique case (idx_reg)
            POS_AT:      cur_byte = CH_AT;
            POS_UNIT_HI: begin
                cur_byte = dec_char(d10);
                rem_step = rem_reg - ADDR_W'({10'd0, d10} * SCALE_10);
            end
            POS_UNIT_LO: cur_byte = dec_char(rem_reg[3:0]);
            POS_CMD_W:   cur_byte = CH_W;
            POS_CMD_D: begin
                cur_byte = CH_D;
                rem_step = addr_reg;
            end
            POS_ADDR_3: begin
                cur_byte = dec_char(d1000);
                rem_step = rem_reg - ADDR_W'({10'd0, d1000} * SCALE_1000);
            end
            POS_ADDR_2: begin
                cur_byte = dec_char(d100);
                rem_step = rem_reg - ADDR_W'({10'd0, d100} * SCALE_100);
            end
            POS_ADDR_1: begin
                cur_byte = dec_char(d10);
                rem_step = rem_reg - ADDR_W'({10'd0, d10} * SCALE_10);
            end
            POS_ADDR_0:  cur_byte = dec_char(rem_reg[3:0]);
            POS_MASK_3:  cur_byte = hex_char(mask_hex[15:12]);
            POS_MASK_2:  cur_byte = hex_char(mask_hex[11:8]);
            POS_MASK_1:  cur_byte = hex_char(mask_hex[7:4]);
            POS_MASK_0:  cur_byte = hex_char(mask_hex[3:0]);
            POS_FCS_HI:  cur_byte = hex_char(fcs_reg[7:4]);
            POS_FCS_LO:  cur_byte = hex_char(fcs_reg[3:0]);
            POS_STAR:    cur_byte = CH_STAR;
            POS_CR:      cur_byte = CH_CR;
            default:     cur_byte = CH_CR;
        endcase
    end

    always_comb begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        rem_next       = rem_reg;
        addr_next      = addr_reg;
        mask_next      = mask_reg;
        fcs_next       = fcs_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        if (advance) begin
            out_next.frame_byte = cur_byte;
            out_next.last       = (idx_reg == POS_CR);
            out_valid_next      = 1'b1;
            idx_next            = idx_reg + IDX_W'(1);
            rem_next            = rem_step;
            if (idx_reg < IDX_W'(FCS_SPAN)) begin
                fcs_next = fcs_reg ^ cur_byte;
            end
        end

        if (q_pop) begin
            busy_next = 1'b1;
            idx_next  = POS_AT;
            rem_next  = ADDR_W'(unit_mod);
            addr_next = q_data.addr;
            mask_next = q_data.mask;
            fcs_next  = '0;
        end else if (frame_end) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= POS_AT;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        addr_reg <= addr_next;
        mask_reg <= mask_next;
        fcs_reg  <= fcs_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_last_is_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.last |-> out_reg.frame_byte == CH_CR)
        else $error("last flag set on a byte other than carriage return");

    a_idx_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg <= POS_CR)
        else $error("byte position ran past the end of the frame");

    a_load_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> busy_reg && idx_reg == POS_AT && fcs_reg == '0)
        else $error("new frame did not start at the first byte with a clear FCS");

    a_frame_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && idx_reg == POS_AT |=> out_valid_reg && out_reg.frame_byte == CH_AT)
        else $error("frame did not open with the start character");

endmodule

@@ hw/rtl/host_link_result_frame_encoder_core.sv @@
// Top level of the host link result frame encoder.
`timescale 1ns / 1ps

// Usage:
// Each transaction on the s_ channel carries ten channel result codes and a
// category. Every channel whose code equals the category sets one bit of a
// match mask, and the block answers with a 17-byte ASCII write command on the
// m_ channel, one byte per transaction: '@', two unit digits, "WD", four
// digits of the word address base + 2 * category, four hex digits of the mask,
// two hex digits of the XOR of the first 13 bytes, '*' and a carriage return.
// m_data.last marks the carriage return.
// A taken request passes the queue and the sequencer state before the first
// byte of its frame reaches the output register; the frame then goes out one
// byte per cycle while the receiver is ready, and a queued next frame follows
// with no gap; the byte sequencer sets this rate. A two-entry queue sits
// between the classifier and the sequencer, so new requests are taken while
// a frame is still going out; when the receiver stalls, the current byte
// holds in the output register and s_ready drops once the queue is full.
// Write the register port only while the block is idle (not enforced).
// Reset empties queue and output stage; loads unit number 0, base address 404.

module host_link_result_frame_encoder_core
    import hlfe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    logic [UNIT_W-1:0] unit_reg, unit_next;
    logic [ADDR_W-1:0] base_reg, base_next;

    logic q_ready;
    logic q_push;
    cmd_t q_wr_data;
    logic q_valid;
    logic q_pop;
    cmd_t q_rd_data;

    // Configuration registers; the index selects which one a write lands in.
    always_comb begin
        unit_next = unit_reg;
        base_next = base_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_UNIT_NUMBER: unit_next = cfg_wdata[UNIT_W-1:0];
                REG_BASE_ADDR:   base_next = cfg_wdata[ADDR_W-1:0];
                default:         unit_next = unit_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg <= '0;
            base_reg <= ADDR_W'(404);
        end else begin
            unit_reg <= unit_next;
            base_reg <= base_next;
        end
    end

    // The classifier builds the mask and the wrapped word address per request.
    hlfe_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .base_addr (base_reg),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    hlfe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .in_ready  (q_ready),
        .wr_data   (q_wr_data),
        .pop       (q_pop),
        .out_valid (q_valid),
        .rd_data   (q_rd_data)
    );

    // The sequencer turns one queued request into the 17 frame bytes.
    hlfe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .unit_number (unit_reg),
        .q_valid     (q_valid),
        .q_data      (q_rd_data),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
